// ===== rtl/hcbd_pkg.sv =====
// Shared types, codes and helpers for the chunked body decoder.
// No dependencies; imported by hcbd_core and http_chunked_body_decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

    // Default width of the chunk size counter
    localparam int SIZE_WIDTH_DEF = 32;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ERROR  = 2'd1;
    localparam logic [1:0] ST_ENDED  = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    // Line terminator characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // One result item
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [1:0] status;
    } result_t;

    // Decoder state flags seen by the top level
    typedef struct packed {
        logic done;
        logic error;
    } core_flags_t;

    // Hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/hcbd_core.sv =====
// Parser state machine of the chunked body decoder: phase and chunk counter.
// Depends on hcbd_pkg.
`timescale 1ns / 1ps

module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,       // consume in_byte this cycle
    input  logic [7:0]  in_byte,
    output result_t     result,     // result for in_byte in the current state
    output core_flags_t flags
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_SIZE_LF,
        PH_DATA,
        PH_TRAIL_CR,
        PH_TRAIL_LF,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [SIZE_WIDTH-1:0]   remaining_reg;
    logic [SIZE_WIDTH-1:0]   remaining_next;
    logic [4:0]              hex;

    assign hex = hex_value(in_byte);

    // Work out next state and the result for this byte
    always_comb
    begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        result.data_valid = 1'b0;
        result.data_byte  = 8'd0;
        result.status     = ST_OK;
        case (phase_reg)
            PH_SIZE:
            begin
                if (in_byte == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
                else if (!hex[4] || (remaining_reg[SIZE_WIDTH-1 -: 4] != 4'd0))
                begin
                    phase_next    = PH_ERROR;
                    result.status = ST_ERROR;
                end
                else
                begin
                    remaining_next = {remaining_reg[SIZE_WIDTH-5:0], hex[3:0]};
                end
            end
            PH_SIZE_LF:
            begin
                if (in_byte != CH_LF)
                begin
                    phase_next    = PH_ERROR;
                    result.status = ST_ERROR;
                end
                else if (remaining_reg == '0)
                begin
                    // empty or zero size line: last chunk, mark with one
                    remaining_next = SIZE_WIDTH'(1);
                    phase_next     = PH_TRAIL_CR;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.data_valid = 1'b1;
                result.data_byte  = in_byte;
                remaining_next    = remaining_reg - SIZE_WIDTH'(1);
                if (remaining_reg == SIZE_WIDTH'(1))
                begin
                    phase_next = PH_TRAIL_CR;
                end
            end
            PH_TRAIL_CR:
            begin
                if (in_byte == CH_CR)
                begin
                    phase_next = PH_TRAIL_LF;
                end
                else
                begin
                    phase_next    = PH_ERROR;
                    result.status = ST_ERROR;
                end
            end
            PH_TRAIL_LF:
            begin
                if (in_byte != CH_LF)
                begin
                    phase_next    = PH_ERROR;
                    result.status = ST_ERROR;
                end
                else if (remaining_reg != '0)
                begin
                    remaining_next = '0;
                    phase_next     = PH_DONE;
                    result.status  = ST_ENDED;
                end
                else
                begin
                    phase_next = PH_SIZE;
                end
            end
            PH_DONE:
            begin
                result.status = ST_CLOSED;
            end
            default:
            begin
                phase_next    = PH_ERROR;
                result.status = ST_ERROR;
            end
        endcase
    end

    // Hold state; advance only when an item is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            remaining_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    assign flags.done  = (phase_reg == PH_DONE);
    assign flags.error = (phase_reg == PH_ERROR);

endmodule

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the chunked transfer body decoder: input register, parser, result register.
// Depends on hcbd_pkg and hcbd_core.
//
//   channel   dir   tdata                 tuser                   accepted when
//   s_axis    in    [7:0] in_byte         -                       tvalid & tready
//   m_axis    out   [7:0] data_byte       [0] data_valid,         tvalid & tready
//                                         [2:1] status
//
// One item per clock sustained while m_axis takes every result; each item passes the input
// register, then the parser into the result register, before it is offered on m_axis.
// The parser state advances as an item moves from the input to the result register.
// Reset clears both registers' valid flags and puts the parser at the start of a size line.
// A stalled output holds its result; the input register still takes one more item.
`timescale 1ns / 1ps

module http_chunked_body_decoder
    import hcbd_pkg::*;
#(
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [2:0] m_axis_tuser    // [0] data_valid, [2:1] status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;
    logic        advance;
    result_t     core_result;
    core_flags_t core_flags;

    // Move an item into the result register when that register is free or its result is being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    hcbd_core #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .result  (core_result),
        .flags   (core_flags)
    );

    // Register the result; drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg.data_byte;
    assign m_axis_tuser  = {out_result_reg.status, out_result_reg.data_valid};

    // Error phase is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        core_flags.error |=> core_flags.error)
        else $error("decoder left the error phase");

    // End of body is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        core_flags.done |=> core_flags.done)
        else $error("decoder left the closed phase");

    // A payload byte always carries status ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tuser[2:1] == ST_OK))
        else $error("payload byte with non-ok status");

    // A non-payload result carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
        else $error("non-payload result with nonzero byte");

    // A stalled, full pipeline takes no new item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both registers are full");

endmodule
